/* src/conv3x3_filter_unit_macros.svh */
// conv3x3_filter_unit_macros.svh: assertion macros for the 3x3 filter
// expects clk and rst_n in the scope where a macro is used
`ifndef CONV3X3_FILTER_UNIT_MACROS_SVH
`define CONV3X3_FILTER_UNIT_MACROS_SVH

// clocked check, off while reset is applied
`define C3F_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("conv3x3 filter check failed");

// same-cycle implication
`define C3F_IMPLIES(label, lhs, rhs) \
    `C3F_ASSERT(label, (lhs) |-> (rhs))

`endif

/* src/c3f_pkg.sv */
// c3f_pkg.sv: shared types and constants of the 3x3 convolution filter
// no dependencies
`timescale 1ns / 1ps

package c3f_pkg;

    localparam int PIX_W  = 8;
    localparam int OUT_W  = 28;
    localparam int CFG_W  = 48;
    localparam int SLOT_W = 16;
    localparam int IDX_W  = 3;
    localparam int WREG_W = 11;
    localparam int HREG_W = 16;

    // configuration register reset values
    localparam logic [CFG_W-1:0]  COEF_TOP_RESET    = '0;
    localparam logic [CFG_W-1:0]  COEF_MID_RESET    = 48'h0000_0100_0000;
    localparam logic [CFG_W-1:0]  COEF_BOTTOM_RESET = '0;
    localparam logic [WREG_W-1:0] WIDTH_RESET       = 11'd1024;
    localparam logic [HREG_W-1:0] HEIGHT_RESET      = 16'd1024;

    // configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_COEF_TOP,
        REG_COEF_MID,
        REG_COEF_BOTTOM,
        REG_WIDTH,
        REG_HEIGHT
    } cfg_index_t;

    // one window column: [0] top row, [1] middle row, [2] bottom row
    typedef logic [2:0][PIX_W-1:0] pix_col_t;

    // per-stage load enables sent to every cell
    typedef struct packed {
        logic shift;
        logic mul_en;
        logic sum_en;
    } cell_ctrl_t;

endpackage

/* src/c3f_line_buf.sv */
// c3f_line_buf.sv: two line memories holding the previous two image rows
// depends on c3f_pkg
`timescale 1ns / 1ps

module c3f_line_buf #(
    parameter int MAX_WIDTH = 1024,
    parameter int ADDR_W    = $clog2(MAX_WIDTH)
) (
    input  logic                       clk,
    input  logic                       rd_en,
    input  logic                       wr_a_en,
    input  logic [ADDR_W-1:0]          addr,
    input  logic [c3f_pkg::PIX_W-1:0]  pixel,
    input  logic                       wr_b_en,
    input  logic [ADDR_W-1:0]          addr_b,
    output logic [c3f_pkg::PIX_W-1:0]  top,
    output logic [c3f_pkg::PIX_W-1:0]  mid
);

    logic [c3f_pkg::PIX_W-1:0] mem_a [MAX_WIDTH];
    logic [c3f_pkg::PIX_W-1:0] mem_b [MAX_WIDTH];
    logic [c3f_pkg::PIX_W-1:0] top_reg;
    logic [c3f_pkg::PIX_W-1:0] mid_reg;

    // previous row: read old value, write new pixel at the same column
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            mid_reg <= mem_a[addr];
        end
        if (wr_a_en)
        begin
            mem_a[addr] <= pixel;
        end
    end

    // row before that: takes the value moved out of the previous row
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            top_reg <= mem_b[addr];
        end
        if (wr_b_en)
        begin
            mem_b[addr_b] <= mid_reg;
        end
    end

    assign top = top_reg;
    assign mid = mid_reg;

endmodule

/* src/c3f_cell.sv */
// c3f_cell.sv: one window column with its three multipliers and column sum
// depends on c3f_pkg
`timescale 1ns / 1ps

module c3f_cell #(
    parameter int COEF_BITS = 16,
    parameter int PROD_W    = COEF_BITS + c3f_pkg::PIX_W + 1
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  c3f_pkg::cell_ctrl_t                 ctrl,
    input  c3f_pkg::pix_col_t                   col_in,
    input  logic [2:0][COEF_BITS-1:0]           coef,
    output c3f_pkg::pix_col_t                   col_out,
    output logic signed [c3f_pkg::OUT_W-1:0]    col_sum
);

    c3f_pkg::pix_col_t                  col_reg;
    logic signed [PROD_W-1:0]           prod_reg  [3];
    logic signed [PROD_W-1:0]           prod_next [3];
    logic signed [c3f_pkg::OUT_W-1:0]   sum_reg;
    logic signed [c3f_pkg::OUT_W-1:0]   sum_next;

    // window column, shifted in from the right neighbor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
        end
        else if (ctrl.shift)
        begin
            col_reg <= col_in;
        end
    end

    // signed coefficient times unsigned pixel
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            prod_next[i] = $signed(coef[i]) * $signed({1'b0, col_reg[i]});
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                prod_reg[i] <= prod_next[i];
            end
        end
    end

    // column sum, modulo the output width
    assign sum_next = c3f_pkg::OUT_W'(prod_reg[0]) + c3f_pkg::OUT_W'(prod_reg[1])
                    + c3f_pkg::OUT_W'(prod_reg[2]);

    always_ff @(posedge clk)
    begin
        if (ctrl.sum_en)
        begin
            sum_reg <= sum_next;
        end
    end

    assign col_out = col_reg;
    assign col_sum = sum_reg;

endmodule

/* src/conv3x3_filter_unit.sv */
// conv3x3_filter_unit.sv: top level of the 3x3 convolution filter
// depends on c3f_pkg, c3f_line_buf, c3f_cell, conv3x3_filter_unit_macros.svh
`timescale 1ns / 1ps
`include "conv3x3_filter_unit_macros.svh"

// Takes 8-bit pixels in raster order and returns, for every interior pixel, the
// Q8.8-weighted sum of its 3x3 neighborhood as a 28-bit signed value with 8
// fractional bits (wraps, never saturates). Border pixels give no result;
// last_of_frame marks the final interior pixel. Results pass the stages line
// memory read, window shift, multiply, column sum and final sum. Sustained rate
// is one pixel per clock while result_ready is high, set by the single read and
// write port of each line memory and by the three-cell window chain; a stalled
// output is absorbed by the empty stages of the pipeline before the input is
// held. The line memories are MAX_WIDTH entries each and need no clearing after
// reset. Configuration is written through cfg_we/cfg_index/cfg_data while the
// filter is idle; the user, not the block, must ensure this.
module conv3x3_filter_unit #(
    parameter int MAX_WIDTH = 1024,
    parameter int COEF_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [c3f_pkg::IDX_W-1:0]           cfg_index,
    input  logic [c3f_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                pixel_valid,
    output logic                                pixel_ready,
    input  logic [c3f_pkg::PIX_W-1:0]           pixel,
    output logic                                result_valid,
    input  logic                                result_ready,
    output logic signed [c3f_pkg::OUT_W-1:0]    filtered_value,
    output logic                                last_of_frame
);

    localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CNT_W  = $clog2(MAX_WIDTH + 1);
    localparam int EW_W   = (CNT_W > c3f_pkg::WREG_W) ? CNT_W : c3f_pkg::WREG_W;
    localparam int HW     = c3f_pkg::HREG_W;

    // configuration
    logic [c3f_pkg::CFG_W-1:0]  coef_top_reg;
    logic [c3f_pkg::CFG_W-1:0]  coef_mid_reg;
    logic [c3f_pkg::CFG_W-1:0]  coef_bot_reg;
    logic [c3f_pkg::WREG_W-1:0] width_reg;
    logic [HW-1:0]              height_reg;

    // frame position
    logic [CNT_W-1:0] col_reg;
    logic [CNT_W-1:0] col_next;
    logic [HW-1:0]    row_reg;
    logic [HW-1:0]    row_next;

    logic [EW_W-1:0]  eff_w;
    logic [HW-1:0]    eff_h;
    logic [CNT_W-1:0] cur_col;
    logic [HW-1:0]    cur_row;
    logic [EW_W-1:0]  col_plus;
    logic             cur_emit;
    logic             cur_last;

    // pipeline control
    logic              accept;
    logic              out_en;
    logic              sum_en;
    logic              mul_en;
    logic              win_en;
    logic              commit;

    logic              s1_valid_reg;
    logic              s1_emit_reg;
    logic              s1_last_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic [c3f_pkg::PIX_W-1:0] s1_px_reg;
    logic              v2_reg;
    logic              last2_reg;
    logic              v3_reg;
    logic              last3_reg;
    logic              v4_reg;
    logic              last4_reg;
    logic              out_valid_reg;
    logic              out_last_reg;
    logic signed [c3f_pkg::OUT_W-1:0] out_value_reg;
    logic signed [c3f_pkg::OUT_W-1:0] out_value_next;

    logic [c3f_pkg::PIX_W-1:0] lb_top;
    logic [c3f_pkg::PIX_W-1:0] lb_mid;

    c3f_pkg::cell_ctrl_t ctrl;
    c3f_pkg::pix_col_t   col_new;
    c3f_pkg::pix_col_t   col_2;
    c3f_pkg::pix_col_t   col_1;
    logic [2:0][COEF_BITS-1:0] coef_c0;
    logic [2:0][COEF_BITS-1:0] coef_c1;
    logic [2:0][COEF_BITS-1:0] coef_c2;
    logic signed [c3f_pkg::OUT_W-1:0] csum_0;
    logic signed [c3f_pkg::OUT_W-1:0] csum_1;
    logic signed [c3f_pkg::OUT_W-1:0] csum_2;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_top_reg <= c3f_pkg::COEF_TOP_RESET;
            coef_mid_reg <= c3f_pkg::COEF_MID_RESET;
            coef_bot_reg <= c3f_pkg::COEF_BOTTOM_RESET;
            width_reg    <= c3f_pkg::WIDTH_RESET;
            height_reg   <= c3f_pkg::HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (c3f_pkg::cfg_index_t'(cfg_index))
                c3f_pkg::REG_COEF_TOP:    coef_top_reg <= cfg_data;
                c3f_pkg::REG_COEF_MID:    coef_mid_reg <= cfg_data;
                c3f_pkg::REG_COEF_BOTTOM: coef_bot_reg <= cfg_data;
                c3f_pkg::REG_WIDTH:       width_reg    <= cfg_data[c3f_pkg::WREG_W-1:0];
                c3f_pkg::REG_HEIGHT:      height_reg   <= cfg_data[HW-1:0];
                default: ;
            endcase
        end
    end

    // clamped geometry
    always_comb
    begin
        eff_w = EW_W'(width_reg);
        if (eff_w < EW_W'(3))
        begin
            eff_w = EW_W'(3);
        end
        else if (eff_w > EW_W'(MAX_WIDTH))
        begin
            eff_w = EW_W'(MAX_WIDTH);
        end
        eff_h = (height_reg < HW'(3)) ? HW'(3) : height_reg;
    end

    // position of the incoming pixel and the position after it
    always_comb
    begin
        cur_col = col_reg;
        cur_row = row_reg;
        if (EW_W'(col_reg) >= eff_w)
        begin
            cur_col = '0;
            cur_row = row_reg + HW'(1);
        end
        if (cur_row >= eff_h)
        begin
            cur_row = '0;
            cur_col = '0;
        end
        col_plus = EW_W'(cur_col) + EW_W'(1);
        if (col_plus >= eff_w)
        begin
            col_next = '0;
            row_next = ({1'b0, cur_row} + 17'd1 >= {1'b0, eff_h}) ? '0
                                                                   : cur_row + HW'(1);
        end
        else
        begin
            col_next = CNT_W'(col_plus);
            row_next = cur_row;
        end
        cur_emit = (cur_row >= HW'(2)) && (cur_col >= CNT_W'(2));
        cur_last = (cur_row == eff_h - HW'(1)) && (EW_W'(cur_col) == eff_w - EW_W'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // stage enables: a stage loads when it is empty or its content moves on
    assign out_en      = !out_valid_reg || result_ready;
    assign sum_en      = !v4_reg || out_en;
    assign mul_en      = !v3_reg || sum_en;
    assign win_en      = !v2_reg || mul_en;
    assign commit      = s1_valid_reg && win_en;
    assign pixel_ready = !s1_valid_reg || win_en;
    assign accept      = pixel_valid && pixel_ready;

    // stage 1: line memory read in flight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (pixel_ready)
        begin
            s1_valid_reg <= pixel_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_emit_reg <= cur_emit;
            s1_last_reg <= cur_last;
            s1_addr_reg <= cur_col[ADDR_W-1:0];
            s1_px_reg   <= pixel;
        end
    end

    c3f_line_buf #(
        .MAX_WIDTH (MAX_WIDTH),
        .ADDR_W    (ADDR_W)
    ) u_line_buf (
        .clk     (clk),
        .rd_en   (pixel_ready),
        .wr_a_en (accept),
        .addr    (cur_col[ADDR_W-1:0]),
        .pixel   (pixel),
        .wr_b_en (commit),
        .addr_b  (s1_addr_reg),
        .top     (lb_top),
        .mid     (lb_mid)
    );

    // valid bits of window, product and column-sum stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (win_en)
            begin
                v2_reg <= s1_valid_reg && s1_emit_reg;
            end
            if (mul_en)
            begin
                v3_reg <= v2_reg;
            end
            if (sum_en)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (win_en)
        begin
            last2_reg <= s1_last_reg;
        end
        if (mul_en)
        begin
            last3_reg <= last2_reg;
        end
        if (sum_en)
        begin
            last4_reg <= last3_reg;
        end
    end

    // cell chain: new column enters on the right, moves left
    assign ctrl.shift  = commit;
    assign ctrl.mul_en = mul_en;
    assign ctrl.sum_en = sum_en;
    assign col_new     = {s1_px_reg, lb_mid, lb_top};

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            coef_c0[0][k] = coef_top_reg[k];
        end
        coef_c0[0] = coef_top_reg[0 +: COEF_BITS];
        coef_c0[1] = coef_mid_reg[0 +: COEF_BITS];
        coef_c0[2] = coef_bot_reg[0 +: COEF_BITS];
        coef_c1[0] = coef_top_reg[c3f_pkg::SLOT_W +: COEF_BITS];
        coef_c1[1] = coef_mid_reg[c3f_pkg::SLOT_W +: COEF_BITS];
        coef_c1[2] = coef_bot_reg[c3f_pkg::SLOT_W +: COEF_BITS];
        coef_c2[0] = coef_top_reg[2*c3f_pkg::SLOT_W +: COEF_BITS];
        coef_c2[1] = coef_mid_reg[2*c3f_pkg::SLOT_W +: COEF_BITS];
        coef_c2[2] = coef_bot_reg[2*c3f_pkg::SLOT_W +: COEF_BITS];
    end

    c3f_cell #(.COEF_BITS(COEF_BITS)) u_cell_2 (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .col_in  (col_new),
        .coef    (coef_c2),
        .col_out (col_2),
        .col_sum (csum_2)
    );

    c3f_cell #(.COEF_BITS(COEF_BITS)) u_cell_1 (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .col_in  (col_2),
        .coef    (coef_c1),
        .col_out (col_1),
        .col_sum (csum_1)
    );

    c3f_cell #(.COEF_BITS(COEF_BITS)) u_cell_0 (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .col_in  (col_1),
        .coef    (coef_c0),
        .col_out (),
        .col_sum (csum_0)
    );

    // final sum and output register
    assign out_value_next = csum_0 + csum_1 + csum_2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_en)
        begin
            out_valid_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_en)
        begin
            out_value_reg <= out_value_next;
            out_last_reg  <= last4_reg;
        end
    end

    assign result_valid   = out_valid_reg;
    assign filtered_value = out_value_reg;
    assign last_of_frame  = out_last_reg;

    // input stalls only when every stage holds a request
    `C3F_IMPLIES(a_stall_full, !pixel_ready,
        s1_valid_reg && v2_reg && v3_reg && v4_reg && out_valid_reg && !result_ready)
    // an emitted request always sits at column two or beyond
    `C3F_IMPLIES(a_emit_col, s1_valid_reg && s1_emit_reg, s1_addr_reg >= ADDR_W'(2))
    // the frame end marker is only set on an interior pixel
    `C3F_IMPLIES(a_last_emit, s1_valid_reg && s1_last_reg, s1_emit_reg)

endmodule
